>>> hdl/punr_pkg.sv
// shared types, constants and factorial table for the permutation unrank unit
`default_nettype none

package punr_pkg;

	// field widths
	localparam int RankW = 41;
	localparam int ElemW = 4;
	localparam int LenW  = 4;

	// longest permutation the element field can carry
	localparam int LenLimit      = 15;
	localparam int MaxLenDefault = 15;

	// factorials 0! .. 15!
	localparam int FactN = 16;
	localparam logic [RankW-1:0] FactTable [FactN] = '{
		41'd1, 41'd1, 41'd2, 41'd6, 41'd24, 41'd120, 41'd720, 41'd5040,
		41'd40320, 41'd362880, 41'd3628800, 41'd39916800, 41'd479001600,
		41'd6227020800, 41'd87178291200, 41'd1307674368000
	};

	// sequencer states
	typedef enum logic [1:0] {
		St_Idle,
		St_Check,
		St_Seed,
		St_Digit
	} punr_state_t;

endpackage

`default_nettype wire

>>> hdl/punr_next_free.sv
// lowest free value at or above a starting bit position of the used-marks mask
`default_nettype none

module punr_next_free import punr_pkg::*; #(
	parameter int MARK_W = MaxLenDefault
) (
	input  logic [MARK_W-1:0] free_mask,
	input  logic [ElemW-1:0]  from_idx,
	output logic [ElemW-1:0]  pick
);

	// priority encode from the top down so the lowest match wins, 0 when none
	always_comb begin
		pick = '0;
		for (int i = MARK_W - 1; i >= 0; i--) begin
			if (free_mask[i] && (ElemW'(i) >= from_idx)) begin
				pick = ElemW'(i + 1);
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/permutation_unrank_unit.sv
// Permutation unrank unit: takes a zero-based lexicographic rank on the slave stream and
// returns the permutation of 1..L of that rank on the master stream, one element per
// request, tlast on the final element, with L the configured length (0 reads as 1, values
// above MAX_LEN read as MAX_LEN). A rank of L! or more gives a single request with element 0,
// tlast and the range-error flag in tuser. One shared 42-bit subtractor does the range check
// and the digit extraction by repeated subtraction of (left-1)!, while a priority encoder
// walks the free values in step with each subtraction, so the subtract loop and any output
// stall set how long a rank takes. A new rank is taken once the last element is in the
// output register, even while that element still waits.
`default_nettype none

module permutation_unrank_unit import punr_pkg::*; #(
	parameter int MAX_LEN = MaxLenDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write: perm_length
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,   // [3:0] perm_length
	// rank requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,    // [40:0] rank_value, [47:41] zero
	// element requests
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [3:0] element, [7:4] zero
	output logic        m_tlast,    // last
	output logic        m_tuser     // [0] range_error
);

	localparam int EFF_MAX = (MAX_LEN < LenLimit) ? MAX_LEN : LenLimit;
	localparam int MARK_W  = EFF_MAX;

	punr_state_t state_q, state_d;

	logic [LenW-1:0]   perm_length_q;
	logic [LenW-1:0]   eff_len;
	logic [LenW-1:0]   len_q;
	logic [LenW-1:0]   left_q;
	logic [RankW-1:0]  rank_q;
	logic [RankW-1:0]  fact_q;
	logic [RankW-1:0]  fact_sel;
	logic [RankW-1:0]  sub_opnd;
	logic [RankW:0]    diff;
	logic              borrow;
	logic [MARK_W-1:0] used_q;
	logic [MARK_W-1:0] free_mask;
	logic [MARK_W-1:0] mark_bit;
	logic [ElemW-1:0]  cand_q;
	logic [ElemW-1:0]  from_idx;
	logic [ElemW-1:0]  next_pick;
	logic [ElemW-1:0]  elem_q;
	logic              last_q;
	logic              err_q;
	logic              out_valid_q;
	logic              out_free;

	// sequencer strobes
	logic take_rank;
	logic emit_err;
	logic start_elems;
	logic seed;
	logic sub_step;
	logic emit_elem;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perm_length_q <= LenW'(LenLimit);
		end else if (cfg_valid) begin
			perm_length_q <= cfg_data;
		end
	end

	// length clamp
	always_comb begin
		eff_len = perm_length_q;
		if (eff_len == '0) begin
			eff_len = LenW'(1);
		end
		if (eff_len > LenW'(EFF_MAX)) begin
			eff_len = LenW'(EFF_MAX);
		end
	end

	// shared factorial lookup and subtractor
	assign fact_sel = (state_q == St_Check) ? FactTable[len_q] : FactTable[left_q - LenW'(1)];
	assign sub_opnd = (state_q == St_Check) ? fact_sel : fact_q;
	assign diff     = {1'b0, rank_q} - {1'b0, sub_opnd};
	assign borrow   = diff[RankW];

	// free values below the length
	always_comb begin
		for (int i = 0; i < MARK_W; i++) begin
			free_mask[i] = !used_q[i] && (LenW'(i) < len_q);
			mark_bit[i]  = (cand_q == ElemW'(i + 1));
		end
	end

	assign from_idx = (state_q == St_Seed) ? '0 : cand_q;

	punr_next_free #(
		.MARK_W(MARK_W)
	) u_next_free (
		.free_mask(free_mask),
		.from_idx (from_idx),
		.pick     (next_pick)
	);

	assign out_free = !out_valid_q || m_tready;

	// next state and strobes
	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		take_rank   = 1'b0;
		emit_err    = 1'b0;
		start_elems = 1'b0;
		seed        = 1'b0;
		sub_step    = 1'b0;
		emit_elem   = 1'b0;
		case (state_q)
			St_Idle: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					take_rank = 1'b1;
					state_d   = St_Check;
				end
			end
			St_Check: begin
				if (!borrow) begin
					if (out_free) begin
						emit_err = 1'b1;
						state_d  = St_Idle;
					end
				end else begin
					start_elems = 1'b1;
					state_d     = St_Seed;
				end
			end
			St_Seed: begin
				seed    = 1'b1;
				state_d = St_Digit;
			end
			St_Digit: begin
				if (!borrow) begin
					sub_step = 1'b1;
				end else if (out_free) begin
					emit_elem = 1'b1;
					state_d   = (left_q == LenW'(1)) ? St_Idle : St_Seed;
				end
			end
			default: begin
				state_d = St_Idle;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= St_Idle;
		end else begin
			state_q <= state_d;
		end
	end

	// decode datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
			left_q <= '0;
			used_q <= '0;
		end else begin
			if (take_rank) begin
				rank_q <= s_tdata[RankW-1:0];
			end else if (emit_err) begin
				rank_q <= '0;
			end else if (sub_step) begin
				rank_q <= diff[RankW-1:0];
			end
			if (emit_err) begin
				left_q <= '0;
				used_q <= '0;
			end else if (start_elems) begin
				left_q <= len_q;
				used_q <= '0;
			end else if (emit_elem) begin
				left_q <= left_q - LenW'(1);
				used_q <= used_q | mark_bit;
			end
		end
	end

	// per-rank and per-element working registers
	always_ff @(posedge clk) begin
		if (take_rank) begin
			len_q <= eff_len;
		end
		if (seed) begin
			fact_q <= fact_sel;
		end
		if (seed || sub_step) begin
			cand_q <= next_pick;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_err || emit_elem) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_err) begin
			elem_q <= '0;
			last_q <= 1'b1;
			err_q  <= 1'b1;
		end else if (emit_elem) begin
			elem_q <= cand_q;
			last_q <= (left_q == LenW'(1));
			err_q  <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, elem_q};
	assign m_tlast  = last_q;
	assign m_tuser  = err_q;

endmodule

`default_nettype wire

>>> sim/tb_permutation_unrank_unit.sv
// self-checking testbench for the permutation unrank unit with a scoreboard class
`default_nettype none

module tb_permutation_unrank_unit;
	import punr_pkg::*;

	localparam int WatchdogLimit = 4000;
	localparam int DrainCycles   = 160;
	localparam longint unsigned RankMask = (64'd1 << RankW) - 64'd1;

	// one element request as the block should return it
	typedef struct packed {
		logic [ElemW-1:0] element;
		logic             last;
		logic             range_error;
	} element_req_t;

	// predicts element requests from accepted ranks and checks the returned ones
	class rank_scoreboard;
		element_req_t    expected_q[$];
		logic [LenW-1:0] length_reg;
		int unsigned     mismatches;
		int unsigned     ranks_noted;
		int unsigned     elements_checked;
		int unsigned     overflow_ranks;
		bit [LenLimit:0] lengths_seen;

		function new();
			length_reg       = 4'd15;
			mismatches       = 0;
			ranks_noted      = 0;
			elements_checked = 0;
			overflow_ranks   = 0;
			lengths_seen     = '0;
		endfunction

		static function longint unsigned factorial(int unsigned n);
			longint unsigned prod;
			prod = 1;
			for (int unsigned k = 2; k <= n; k++)
				prod = prod * k;
			return prod;
		endfunction

		// zero reads as one, anything above the limit saturates
		static function int unsigned eff_length(logic [LenW-1:0] raw);
			int unsigned len;
			len = raw;
			if (len == 0)
				len = 1;
			if (len > LenLimit)
				len = LenLimit;
			return len;
		endfunction

		function void set_length(logic [LenW-1:0] value);
			length_reg = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// factorial number system decode of one rank
		function void note_rank(logic [RankW-1:0] rank);
			int unsigned     len;
			longint unsigned remainder;
			longint unsigned fact;
			longint unsigned digit;
			longint unsigned seen;
			bit [LenLimit:1] taken;
			element_req_t    req;
			int unsigned     pick;

			len = eff_length(length_reg);
			ranks_noted++;
			lengths_seen[len] = 1'b1;
			remainder = rank;
			if (remainder >= factorial(len)) begin
				overflow_ranks++;
				req.element     = '0;
				req.last        = 1'b1;
				req.range_error = 1'b1;
				expected_q.push_back(req);
				return;
			end
			taken = '0;
			for (int unsigned left = len; left >= 1; left--) begin
				fact      = factorial(left - 1);
				digit     = remainder / fact;
				remainder = remainder % fact;
				seen      = 0;
				pick      = 0;
				for (int unsigned v = 1; v <= len; v++) begin
					if (!taken[v]) begin
						if (seen == digit) begin
							pick = v;
							break;
						end
						seen++;
					end
				end
				if (pick != 0)
					taken[pick] = 1'b1;
				req.element     = pick[ElemW-1:0];
				req.last        = (left == 1);
				req.range_error = 1'b0;
				expected_q.push_back(req);
			end
		endfunction

		// compare one returned element with the oldest prediction
		function void check_element(logic [ElemW-1:0] element, logic last, logic range_error);
			element_req_t want;
			if (expected_q.size() == 0) begin
				$error("element request with nothing expected: element=%0d last=%0d err=%0d",
					element, last, range_error);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			elements_checked++;
			if (element !== want.element) begin
				$error("element: expected %0d, got %0d", want.element, element);
				mismatches++;
			end
			if (last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, last);
				mismatches++;
			end
			if (range_error !== want.range_error) begin
				$error("range_error: expected %0d, got %0d", want.range_error, range_error);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	rank_scoreboard board = new();
	bit          bursts_on;
	int unsigned stall_left;
	int unsigned idle_cycles;
	int unsigned sent;

	permutation_unrank_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// known values on every input from time zero
	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		bursts_on  = 1'b1;
		stall_left = 0;
	end

	// receiver back-pressure in random bursts
	initial begin
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (bursts_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// accepted requests on both streams
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.note_rank(s_tdata[RankW-1:0]);
			if (m_tvalid && m_tready)
				board.check_element(m_tdata[ElemW-1:0], m_tlast, m_tuser);
		end
	end

	// watchdog on cycles without any handshake
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < WatchdogLimit) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no handshake for %0d cycles", WatchdogLimit);
		$display("[FAIL] regression broken");
		$finish;
	end

	// one rank request, with an optional gap in front
	task automatic send_rank(input longint unsigned rank);
		@(negedge clk);
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, rank[RankW-1:0]};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// drop the stream and wait for every predicted element
	task automatic drain_phase();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// length register write, only while idle
	task automatic write_length(input logic [3:0] value);
		drain_phase();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		board.set_length(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random rank for the current length, in range or past L!
	function automatic longint unsigned pick_rank(input int unsigned len, input bit overflow);
		longint unsigned fact;
		longint unsigned raw;
		fact = rank_scoreboard::factorial(len);
		raw  = {$urandom, $urandom};
		if (!overflow)
			return raw % fact;
		case ($urandom_range(0, 2))
			0:       return fact;
			1:       return RankMask;
			default: return fact + raw % ((RankMask + 1) - fact);
		endcase
	endfunction

	task automatic random_phase(input logic [3:0] len_cfg, input int unsigned count);
		int unsigned len;
		len = rank_scoreboard::eff_length(len_cfg);
		write_length(len_cfg);
		repeat (count)
			send_rank(pick_rank(len, $urandom_range(0, 99) < 15));
	endtask

	// stimulus
	initial begin
		sent = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset length of fifteen: extremes and overflow
		send_rank(0);
		send_rank(1);
		send_rank(rank_scoreboard::factorial(15) - 1);
		send_rank(rank_scoreboard::factorial(15));
		send_rank(RankMask);
		send_rank(64'h0AA_AAAA_AAAA);
		send_rank(64'd1 << 40);

		// single element, and zero reading as one
		write_length(4'd1);
		send_rank(0);
		send_rank(1);
		write_length(4'd0);
		send_rank(0);
		send_rank(RankMask);

		// short lengths, then back to fifteen
		write_length(4'd2);
		send_rank(0);
		send_rank(1);
		send_rank(2);
		write_length(4'd7);
		send_rank(5039);
		send_rank(5040);
		send_rank(2520);
		write_length(4'd15);
		send_rank(0);
		send_rank(rank_scoreboard::factorial(15) - 1);

		// random lengths and ranks with idling on both sides
		while (sent < 290)
			random_phase(4'($urandom_range(0, 15)), $urandom_range(4, 24));

		// closing part at full rate
		bursts_on = 1'b0;
		random_phase(4'd15, 30);
		random_phase(4'($urandom_range(0, 15)), 30);

		drain_phase();
		repeat (DrainCycles) @(posedge clk);
		if (board.pending() != 0) begin
			$error("%0d predicted element requests never arrived", board.pending());
			board.mismatches++;
		end

		$display("ranks sent %0d (%0d past L!), elements checked %0d",
			board.ranks_noted, board.overflow_ranks, board.elements_checked);
		$display("effective lengths covered (bit per length): %b", board.lengths_seen);
		if (board.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
